[design/gcc_pkg.sv]
`default_nettype none

package gcc_pkg;

  // field and register widths
  localparam int CFG_W      = 5;
  localparam int VERTEX_W   = 4;
  localparam int COLORING_W = 63;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // parameter defaults
  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_MAX_COLORS   = 16;

  // register reset values
  localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 5'd16;
  localparam logic [CFG_W-1:0] COLOR_COUNT_RST  = 5'd3;

  // register index, taken from paddr[2]
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_COLOR_COUNT  = 1'b1;

  // item kinds
  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

endpackage

`default_nettype wire

[design/graph_coloring_checker.sv]
`default_nettype none

// channel   signals                                        direction
// in        in_valid/in_ready: kind vertex_a vertex_b      into block
//           coloring
// out       out_valid/out_ready: valid_res status          out of block
// apb       psel penable pwrite paddr pwdata prdata pready config regs
//
// a check beat works digit by digit (n = vertex count): each digit is one pass
// of the shared bit-serial divider, then one adjacency row is compared per cycle.
// reset clears the adjacency matrix and restores the registers.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register without holding up the next input beat.
module graph_coloring_checker #(
  parameter int MAX_VERTICES = gcc_pkg::DEF_MAX_VERTICES,
  parameter int MAX_COLORS   = gcc_pkg::DEF_MAX_COLORS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              kind,
  input  wire logic [gcc_pkg::VERTEX_W-1:0]      vertex_a,
  input  wire logic [gcc_pkg::VERTEX_W-1:0]      vertex_b,
  input  wire logic [gcc_pkg::COLORING_W-1:0]    coloring,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   valid_res,
  output logic                                   status,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [gcc_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [gcc_pkg::PDATA_W-1:0]       pwdata,
  output logic [gcc_pkg::PDATA_W-1:0]            prdata,
  output logic                                   pready
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_COLORS);
  localparam int KW = $clog2(MAX_COLORS + 1);
  localparam int FW = gcc_pkg::CFG_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_START,
    S_DIV,
    S_CMP,
    S_FIN
  } state_t;

  state_t state;

  logic [FW-1:0] vertex_count;
  logic [FW-1:0] color_count;
  logic [FW-1:0] n_eff;
  logic [FW-1:0] n_last;
  logic [KW-1:0] k_eff;

  logic [gcc_pkg::VERTEX_W-1:0]   item_a;
  logic [gcc_pkg::VERTEX_W-1:0]   item_b;
  logic [gcc_pkg::COLORING_W-1:0] item_coloring;
  logic                           first;
  logic                           proper;
  logic [VW-1:0]                  vidx;

  logic [MAX_VERTICES-1:0] adjacency [MAX_VERTICES];
  logic [CW-1:0]           color     [MAX_VERTICES];

  logic                           div_start;
  logic                           div_done;
  logic [gcc_pkg::COLORING_W-1:0] div_quot;
  logic [CW-1:0]                  div_rem;

  logic                    out_free;
  logic                    out_load;
  logic                    edge_oor;
  logic                    edge_commit;
  logic                    row_hit;
  logic                    last_row;
  logic [VW-1:0]           a_idx;
  logic [VW-1:0]           b_idx;
  logic [MAX_VERTICES-1:0] a_bit;
  logic [MAX_VERTICES-1:0] b_bit;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= gcc_pkg::VERTEX_COUNT_RST;
      color_count  <= gcc_pkg::COLOR_COUNT_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        gcc_pkg::REG_VERTEX_COUNT: vertex_count <= pwdata[FW-1:0];
        gcc_pkg::REG_COLOR_COUNT:  color_count  <= pwdata[FW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      gcc_pkg::REG_VERTEX_COUNT: prdata = gcc_pkg::PDATA_W'(vertex_count);
      gcc_pkg::REG_COLOR_COUNT:  prdata = gcc_pkg::PDATA_W'(color_count);
      default:                   prdata = '0;
    endcase
  end

  // clamped vertex count and radix
  always_comb begin
    n_eff = (vertex_count > FW'(MAX_VERTICES)) ? FW'(MAX_VERTICES) : vertex_count;
    if (color_count == '0) begin
      k_eff = KW'(1);
    end else if (color_count > FW'(MAX_COLORS)) begin
      k_eff = KW'(MAX_COLORS);
    end else begin
      k_eff = color_count[KW-1:0];
    end
  end

  assign n_last = n_eff - 1'b1;

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign out_load  = ((state == S_EDGE) || (state == S_FIN)) && out_free;
  assign div_start = (state == S_START);

  gcc_div #(
    .MAX_COLORS(MAX_COLORS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (first ? item_coloring : div_quot),
    .divisor   (k_eff),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // edge item
  assign edge_oor    = ({1'b0, item_a} >= n_eff) || ({1'b0, item_b} >= n_eff);
  assign edge_commit = (state == S_EDGE) && out_free && !edge_oor;
  assign a_idx       = item_a[VW-1:0];
  assign b_idx       = item_b[VW-1:0];
  assign a_bit       = MAX_VERTICES'(1) << a_idx;
  assign b_bit       = MAX_VERTICES'(1) << b_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
        adjacency[r] <= '0;
      end
    end else if (edge_commit) begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
        if ((VW'(r) == a_idx) || (VW'(r) == b_idx)) begin
          adjacency[r] <= adjacency[r]
                          | ((VW'(r) == a_idx) ? b_bit : '0)
                          | ((VW'(r) == b_idx) ? a_bit : '0);
        end
      end
    end
  end

  // one adjacency row against all colors, vertices past the count masked
  always_comb begin
    row_hit = 1'b0;
    for (int w = 0; w < MAX_VERTICES; w++) begin
      if (adjacency[vidx][w] && (FW'(w) < n_eff) && (color[vidx] == color[w])) begin
        row_hit = 1'b1;
      end
    end
    last_row = (FW'(vidx) == n_last);
  end

  always_ff @(posedge clk) begin
    if ((state == S_DIV) && div_done) begin
      color[vidx] <= div_rem;
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      first     <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item_a        <= vertex_a;
            item_b        <= vertex_b;
            item_coloring <= coloring;
            first         <= 1'b1;
            if (kind == gcc_pkg::KIND_EDGE) begin
              state <= S_EDGE;
            end else if (n_eff == '0) begin
              proper <= 1'b1;
              state  <= S_FIN;
            end else begin
              vidx  <= n_last[VW-1:0];
              state <= S_START;
            end
          end
        end
        S_EDGE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            valid_res <= 1'b0;
            status    <= edge_oor;
            state     <= S_IDLE;
          end
        end
        S_START: begin
          first <= 1'b0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (vidx == '0) begin
              state <= S_CMP;
            end else begin
              vidx  <= vidx - 1'b1;
              state <= S_START;
            end
          end
        end
        S_CMP: begin
          if (row_hit) begin
            proper <= 1'b0;
            state  <= S_FIN;
          end else if (last_row) begin
            proper <= 1'b1;
            state  <= S_FIN;
          end else begin
            vidx <= vidx + 1'b1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            valid_res <= proper;
            status    <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/gcc_div.sv]
`default_nettype none

// restoring divider, one quotient bit per cycle
module gcc_div #(
  parameter int MAX_COLORS = gcc_pkg::DEF_MAX_COLORS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [gcc_pkg::COLORING_W-1:0]       dividend,
  input  wire logic [$clog2(MAX_COLORS+1)-1:0]      divisor,
  output logic                                      done,
  output logic [gcc_pkg::COLORING_W-1:0]            quotient,
  output logic [$clog2(MAX_COLORS)-1:0]             remainder
);

  localparam int KW    = $clog2(MAX_COLORS + 1);
  localparam int CW    = $clog2(MAX_COLORS);
  localparam int QW    = gcc_pkg::COLORING_W;
  localparam int CNT_W = $clog2(QW);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(QW - 1);

  logic [QW-1:0]    q;
  logic [KW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [KW:0]   trial;
  logic [KW:0]   diff;
  logic          ge;
  logic [KW-1:0] rem_next;

  always_comb begin
    trial    = {rem, q[QW-1]};
    diff     = trial - {1'b0, divisor};
    ge       = trial >= {1'b0, divisor};
    rem_next = ge ? diff[KW-1:0] : trial[KW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
    end else if (busy) begin
      q   <= {q[QW-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient  = q;
  assign remainder = rem[CW-1:0];

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = gcc_pkg::DEF_MAX_VERTICES;
  localparam int NC = gcc_pkg::DEF_MAX_COLORS;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 3000;
  localparam logic [gcc_pkg::COLORING_W-1:0] COLORING_MAX = '1;

  typedef struct packed {
    logic valid_res;
    logic status;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = gcc_pkg::KIND_EDGE;
  logic [gcc_pkg::VERTEX_W-1:0] vertex_a = '0;
  logic [gcc_pkg::VERTEX_W-1:0] vertex_b = '0;
  logic [gcc_pkg::COLORING_W-1:0] coloring = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic valid_res;
  logic status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [gcc_pkg::PADDR_W-1:0] paddr = '0;
  logic [gcc_pkg::PDATA_W-1:0] pwdata = '0;
  logic [gcc_pkg::PDATA_W-1:0] prdata;
  logic pready;

  // shadow of the block: adjacency rows and the two count registers
  logic [NV-1:0] adj_rows [NV];
  logic [gcc_pkg::CFG_W-1:0] n_reg;
  logic [gcc_pkg::CFG_W-1:0] k_reg;
  verdict_t pending_verdicts [$];

  int err_count = 0;
  int cycle_count = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  graph_coloring_checker DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .vertex_a(vertex_a),
    .vertex_b(vertex_b),
    .coloring(coloring),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .valid_res(valid_res),
    .status(status),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned used_vertices();
    return (n_reg > NV) ? NV : n_reg;
  endfunction

  function automatic int unsigned used_colors();
    if (k_reg == 0) return 1;
    return (k_reg > NC) ? NC : k_reg;
  endfunction

  function automatic logic coloring_is_proper(logic [gcc_pkg::COLORING_W-1:0] col);
    int unsigned n;
    longint unsigned k;
    longint unsigned rest;
    int unsigned digit [NV];
    n = used_vertices();
    k = used_colors();
    rest = 64'(col);
    for (int v = 0; v < NV; v++) digit[v] = 0;
    // lowest digit belongs to the last vertex in use
    for (int v = int'(n) - 1; v >= 0; v--) begin
      digit[v] = 32'(rest % k);
      rest = rest / k;
    end
    for (int v = 0; v < n; v++)
      for (int w = 0; w < n; w++)
        if (adj_rows[v][w] && digit[v] == digit[w]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic verdict_t predict_verdict(logic kd, logic [gcc_pkg::VERTEX_W-1:0] a,
                                               logic [gcc_pkg::VERTEX_W-1:0] b,
                                               logic [gcc_pkg::COLORING_W-1:0] col);
    verdict_t res;
    int unsigned n;
    n = used_vertices();
    res = '0;
    if (kd == gcc_pkg::KIND_CHECK) begin
      res.valid_res = coloring_is_proper(col);
    end else if (a >= n || b >= n) begin
      res.status = 1'b1;
    end else begin
      adj_rows[a][b] = 1'b1;
      adj_rows[b][a] = 1'b1;
    end
    return res;
  endfunction

  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return int'($urandom_range(1, 3));
    if (r < 95) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 150));
  endfunction

  // random digits above the n digits in use, kept within 63 bits
  function automatic logic [gcc_pkg::COLORING_W-1:0] add_high_digits(
      logic [gcc_pkg::COLORING_W-1:0] col);
    longint unsigned k;
    longint unsigned kn;
    longint unsigned span;
    k = used_colors();
    kn = 1;
    for (int v = 0; v < used_vertices(); v++) begin
      if (kn > COLORING_MAX / k) return col;
      kn = kn * k;
    end
    span = (COLORING_MAX - col) / kn;
    return gcc_pkg::COLORING_W'(col + kn * ({$urandom, $urandom} % (span + 1)));
  endfunction

  // mostly proper colorings of the current graph, some nudged, some raw noise
  function automatic logic [gcc_pkg::COLORING_W-1:0] pick_coloring();
    int unsigned n;
    int unsigned k;
    int unsigned c;
    int unsigned r;
    int unsigned cv [NV];
    longint unsigned acc;
    bit ok;
    bit found;
    n = used_vertices();
    k = used_colors();
    r = $urandom_range(0, 99);
    ok = (r < 75);
    for (int v = 0; v < n && ok; v++) begin
      found = 1'b0;
      c = $urandom_range(0, k - 1);
      for (int t = 0; t < k && !found; t++) begin
        found = 1'b1;
        for (int w = 0; w < v; w++)
          if (adj_rows[v][w] && cv[w] == c) found = 1'b0;
        if (!found) c = (c + 1) % k;
      end
      cv[v] = c;
      ok = found && !adj_rows[v][v];
    end
    if (ok && r >= 55 && n > 0)
      cv[$urandom_range(0, n - 1)] = $urandom_range(0, k - 1);
    acc = 0;
    for (int v = 0; v < n && ok; v++) begin
      ok = acc <= (COLORING_MAX - cv[v]) / k;
      if (ok) acc = acc * k + cv[v];
    end
    if (!ok) return gcc_pkg::COLORING_W'({$urandom, $urandom});
    return ($urandom_range(0, 3) == 0) ? add_high_digits(gcc_pkg::COLORING_W'(acc))
                                       : gcc_pkg::COLORING_W'(acc);
  endfunction

  task automatic send_cmd(logic kd, logic [gcc_pkg::VERTEX_W-1:0] a,
                          logic [gcc_pkg::VERTEX_W-1:0] b,
                          logic [gcc_pkg::COLORING_W-1:0] col);
    int gap;
    gap = (!quiet && $urandom_range(0, 1) == 1) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= kd;
    vertex_a <= a;
    vertex_b <= b;
    coloring <= col;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_link(logic [gcc_pkg::VERTEX_W-1:0] a,
                           logic [gcc_pkg::VERTEX_W-1:0] b);
    send_cmd(gcc_pkg::KIND_EDGE, a, b, gcc_pkg::COLORING_W'({$urandom, $urandom}));
  endtask

  task automatic send_check(logic [gcc_pkg::COLORING_W-1:0] col);
    send_cmd(gcc_pkg::KIND_CHECK, gcc_pkg::VERTEX_W'($urandom_range(0, 15)),
             gcc_pkg::VERTEX_W'($urandom_range(0, 15)), col);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [gcc_pkg::CFG_W-1:0] value);
    logic [gcc_pkg::PDATA_W-1:0] data;
    data = $urandom;
    data[gcc_pkg::CFG_W-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_counts(logic [gcc_pkg::CFG_W-1:0] n_val,
                            logic [gcc_pkg::CFG_W-1:0] k_val);
    settle();
    write_reg(gcc_pkg::REG_VERTEX_COUNT, n_val);
    write_reg(gcc_pkg::REG_COLOR_COUNT, k_val);
  endtask

  task automatic test_empty_graph();
    send_check(COLORING_MAX);
    send_check('0);
  endtask

  task automatic test_small_graph();
    set_counts(5'd4, 5'd3);
    send_link(4'd0, 4'd1);
    send_link(4'd1, 4'd2);
    send_link(4'd2, 4'd3);
    send_link(4'd3, 4'd0);
    send_link(4'd4, 4'd0);
    send_link(4'd0, 4'd15);
    send_check(63'd10);                   // colors 0 1 0 1
    send_check(63'd5);                    // colors 0 0 1 2
    send_check(add_high_digits(63'd10));
    send_check(COLORING_MAX);
  endtask

  task automatic test_self_loop();
    set_counts(5'd16, 5'd16);
    send_link(4'd15, 4'd14);
    send_link(4'd15, 4'd15);
    send_check(63'h0123456789ABCDEF);     // every vertex its own color
  endtask

  task automatic test_count_clamps();
    set_counts(5'd0, 5'd16);
    send_link(4'd0, 4'd0);
    send_check(gcc_pkg::COLORING_W'({$urandom, $urandom}));
    set_counts(5'd31, 5'd0);
    send_check('0);
    set_counts(5'd3, 5'd31);
    send_check(63'h012);
    send_check(63'h559);
  endtask

  task automatic test_edges_beyond_count();
    set_counts(5'd2, 5'd2);
    send_check(63'd1);
    send_check(63'd3);
    set_counts(5'd1, 5'd1);
    send_check('0);
  endtask

  // output held off long enough that the block backs up into its input
  task automatic test_backpressure();
    set_counts(5'd3, 5'd3);
    hold_req++;
    quiet = 1'b1;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2) send_check(pick_coloring());
      else send_link(gcc_pkg::VERTEX_W'(i % 3), 4'd2);
    end
    quiet = 1'b0;
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    int unsigned r;
    int unsigned n;
    logic [gcc_pkg::CFG_W-1:0] n_val;
    logic [gcc_pkg::CFG_W-1:0] k_val;
    logic [gcc_pkg::VERTEX_W-1:0] a;
    logic [gcc_pkg::VERTEX_W-1:0] b;
    for (int p = 0; p < phases; p++) begin
      // small graphs keep checks short, a few runs at the full size
      r = $urandom_range(0, 99);
      if (r < 70) n_val = gcc_pkg::CFG_W'($urandom_range(1, 6));
      else if (r < 85) n_val = gcc_pkg::CFG_W'($urandom_range(7, 12));
      else if (r < 92) n_val = gcc_pkg::CFG_W'($urandom_range(13, 15));
      else if (r < 96) n_val = 5'd16;
      else if (r < 98) n_val = 5'd0;
      else n_val = gcc_pkg::CFG_W'($urandom_range(17, 31));
      r = $urandom_range(0, 99);
      if (r < 50) k_val = gcc_pkg::CFG_W'($urandom_range(2, 6));
      else if (r < 85) k_val = gcc_pkg::CFG_W'($urandom_range(7, 16));
      else k_val = gcc_pkg::CFG_W'($urandom_range(0, 31));
      set_counts(n_val, k_val);
      quiet = (p == 4);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 1) == 0) begin
          n = used_vertices();
          if (n > 1 && $urandom_range(0, 99) < 85) begin
            a = gcc_pkg::VERTEX_W'($urandom_range(0, n - 1));
            b = gcc_pkg::VERTEX_W'($urandom_range(0, n - 1));
          end else begin
            a = gcc_pkg::VERTEX_W'($urandom_range(0, 15));
            b = gcc_pkg::VERTEX_W'($urandom_range(0, 15));
          end
          // keep self-loops off the low vertices, they would spoil every later check
          if (a == b && a < n && a != NV - 1) b = gcc_pkg::VERTEX_W'(a + 1);
          send_link(a, b);
        end else begin
          send_check(pick_coloring());
        end
      end
      quiet = 1'b0;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    verdict_t want;
    verdict_t got;
    verdict_t fresh;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.valid_res = valid_res;
        got.status = status;
        if (pending_verdicts.size() == 0) begin
          if (err_count < 10)
            $display("result beat with nothing pending: valid_res %0b status %0b",
                     valid_res, status);
          err_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (got !== want) begin
            if (err_count < 10)
              $display("mismatch at cycle %0d: valid_res exp %0b got %0b, status exp %0b got %0b",
                       cycle_count, want.valid_res, got.valid_res, want.status, got.status);
            err_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == gcc_pkg::REG_COLOR_COUNT) k_reg = pwdata[gcc_pkg::CFG_W-1:0];
        else n_reg = pwdata[gcc_pkg::CFG_W-1:0];
      end
      if (in_valid && in_ready) begin
        fresh = predict_verdict(kind, vertex_a, vertex_b, coloring);
        pending_verdicts = {pending_verdicts, fresh};
      end
    end
  end

  always @(posedge clk) begin : receiver
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < 25) begin
      out_ready <= 1'b0;
      stall_left = gap_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NV; i++) adj_rows[i] = '0;
    n_reg = gcc_pkg::VERTEX_COUNT_RST;
    k_reg = gcc_pkg::COLOR_COUNT_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_graph();
    test_small_graph();
    test_self_loop();
    test_count_clamps();
    test_edges_beyond_count();
    test_backpressure();
    test_random_phases(13, 39);
    settle();
    repeat (30) @(posedge clk);
    if (err_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[graph_coloring_checker.f]
design/gcc_pkg.sv
design/gcc_div.sv
design/graph_coloring_checker.sv
tb/sv/tb_top.sv
